### src/awrt_pkg.sv
// ----------------------------------------------------------------------------
// Ack window reliability tracker package
// Shared constants, command and result types for the tracker.
// ----------------------------------------------------------------------------
package awrt_pkg;

  localparam int WIN_BITS   = 32;
  localparam int IDX_W      = $clog2(WIN_BITS);
  localparam int SEQ_W      = 16;
  localparam int QDEPTH     = 2;
  localparam int QPTR_W     = $clog2(QDEPTH);
  localparam int QCNT_W     = $clog2(QDEPTH + 1);
  localparam int CFG_ADDR_W = 3;

  localparam logic [SEQ_W-1:0] SEQ_MAX   = '1;
  localparam logic [SEQ_W-1:0] SEQ_HALF  = {1'b1, {(SEQ_W-1){1'b0}}};
  localparam logic [15:0]      TRIG_RST  = 16'd30;

  // Register index decoded from paddr[2].
  localparam logic REG_RESEND_TRIG = 1'b0;

  typedef enum logic [1:0] {
    OP_CONNECT = 2'd0,
    OP_SEND    = 2'd1,
    OP_POLL    = 2'd2,
    OP_PACKET  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    CMD_CONNECT,
    CMD_SEND,
    CMD_POLL,
    CMD_PKT_SYNC,
    CMD_PKT_DATA
  } cmd_kind_t;

  typedef enum logic [2:0] {
    ST_DONE    = 3'd0,
    ST_SYNCING = 3'd1,
    ST_FULL    = 3'd2,
    ST_OLD     = 3'd3,
    ST_IGNORED = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    LINK_DOWN = 2'd0,
    LINK_SYNC = 2'd1,
    LINK_UP   = 2'd2
  } link_t;

  typedef struct packed {
    cmd_kind_t           kind;
    logic [SEQ_W-1:0]    pkt_seq;
    logic [SEQ_W-1:0]    pkt_ack_no;
    logic [WIN_BITS-1:0] pkt_ack_window;
  } cmd_t;

  typedef struct packed {
    status_t             status;
    logic                tx_valid;
    logic                tx_sync;
    logic [SEQ_W-1:0]    tx_seq;
    logic [SEQ_W-1:0]    hdr_ack_no;
    logic [WIN_BITS-1:0] hdr_ack_window;
    logic [WIN_BITS-1:0] released_mask;
    logic                deliver;
    logic                resend_valid;
    logic [SEQ_W-1:0]    resend_seq;
    link_t               link_state;
  } res_t;

  function automatic logic [SEQ_W-1:0] seq_next(input logic [SEQ_W-1:0] s);
    logic [SEQ_W-1:0] r;
    r = (s == SEQ_MAX) ? SEQ_W'(1) : s + SEQ_W'(1);
    return r;
  endfunction

endpackage

### src/awrt_if.sv
// ----------------------------------------------------------------------------
// Ack window reliability tracker channels
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface awrt_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic        pkt_is_sync;
  logic [15:0] pkt_seq;
  logic [15:0] pkt_ack_no;
  logic [31:0] pkt_ack_window;

  modport source (output valid, op, pkt_is_sync, pkt_seq, pkt_ack_no, pkt_ack_window,
                  input ready);
  modport sink (input valid, op, pkt_is_sync, pkt_seq, pkt_ack_no, pkt_ack_window,
                output ready);
endinterface

interface awrt_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic        tx_valid;
  logic        tx_sync;
  logic [15:0] tx_seq;
  logic [15:0] hdr_ack_no;
  logic [31:0] hdr_ack_window;
  logic [31:0] released_mask;
  logic        deliver;
  logic        resend_valid;
  logic [15:0] resend_seq;
  logic [1:0]  link_state;

  modport source (output valid, status, tx_valid, tx_sync, tx_seq, hdr_ack_no,
                  hdr_ack_window, released_mask, deliver, resend_valid, resend_seq,
                  link_state,
                  input ready);
  modport sink (input valid, status, tx_valid, tx_sync, tx_seq, hdr_ack_no,
                hdr_ack_window, released_mask, deliver, resend_valid, resend_seq,
                link_state,
                output ready);
endinterface

### src/ack_window_reliability_tracker_unit.sv
// ----------------------------------------------------------------------------
// Ack window reliability tracker
// Sequence numbering, ack windows, link state and resend timing for a
// reliable datagram link.
//
//   Channel   Direction   Handshake             Transfer
//   in_ch     sink        valid/ready           one command or packet header
//   out_ch    source      valid/ready           one result per input item
//   APB       slave       psel/penable/pready   resend tick threshold
//
// One item per cycle is sustained while out_ch is not stalled; each item is
// registered in the front queue and then in the back-end result register.
// The back end updates all link state for an item when it pops it.
// Reset is synchronous on rst_n and clears link state, queues and out_ch.valid.
// A stalled output holds its result register and the two-entry queue
// keeps taking input until it fills.
// ----------------------------------------------------------------------------
module ack_window_reliability_tracker_unit import awrt_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  awrt_in_if.sink               in_ch,
  awrt_out_if.source            out_ch,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  logic [15:0] trig_r, trig_nxt;
  logic        q_valid;
  logic        q_pop;
  cmd_t        q_data;

  assign pready = 1'b1;

  always_comb begin
    trig_nxt = trig_r;
    if (psel && penable && pwrite && pready && (paddr[2] == REG_RESEND_TRIG)) begin
      trig_nxt = pwdata[15:0];
    end
    prdata = (paddr[2] == REG_RESEND_TRIG) ? {16'd0, trig_r} : 32'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trig_r <= TRIG_RST;
    end else begin
      trig_r <= trig_nxt;
    end
  end

  awrt_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .q_valid (q_valid),
    .q_data  (q_data),
    .q_pop   (q_pop)
  );

  awrt_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_data  (q_data),
    .q_pop   (q_pop),
    .trig    (trig_r),
    .out_ch  (out_ch)
  );

`ifndef SYNTHESIS
  a_pop_needs_entry: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("back end popped an empty queue");

  a_full_means_pending: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> q_valid)
    else $error("input stalled with an empty queue");

  a_tx_link_state: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.tx_valid) |->
      ((out_ch.tx_seq != 16'd0) &&
       ((out_ch.tx_sync && out_ch.link_state == LINK_SYNC) ||
        (!out_ch.tx_sync && out_ch.link_state == LINK_UP))))
    else $error("new frame inconsistent with link state");

  a_trig_write: assert property (@(posedge clk) disable iff (!rst_n)
    (psel && penable && pwrite && paddr[2] == REG_RESEND_TRIG) |=>
      (trig_r == $past(pwdata[15:0])))
    else $error("threshold register write lost");
`endif

endmodule

### src/awrt_front.sv
// ----------------------------------------------------------------------------
// Ack window tracker front end
// Accepts input transfers, decodes them into commands and queues them.
// ----------------------------------------------------------------------------
module awrt_front import awrt_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  awrt_in_if.sink     in_ch,
  output logic        q_valid,
  output cmd_t        q_data,
  input  logic        q_pop
);

  cmd_t              q_mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  cmd_t              dec;
  logic              push;
  logic              pop;

  always_comb begin
    dec.pkt_seq        = in_ch.pkt_seq;
    dec.pkt_ack_no     = in_ch.pkt_ack_no;
    dec.pkt_ack_window = in_ch.pkt_ack_window;
    case (op_t'(in_ch.op))
      OP_CONNECT: dec.kind = CMD_CONNECT;
      OP_SEND:    dec.kind = CMD_SEND;
      OP_POLL:    dec.kind = CMD_POLL;
      OP_PACKET:  dec.kind = in_ch.pkt_is_sync ? CMD_PKT_SYNC : CMD_PKT_DATA;
      default:    dec.kind = CMD_POLL;
    endcase
  end

  assign in_ch.ready = (cnt_r != QCNT_W'(QDEPTH));
  assign push        = in_ch.valid && in_ch.ready;
  assign q_valid     = (cnt_r != '0);
  assign pop         = q_pop && q_valid;
  assign q_data      = q_mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + QPTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + QPTR_W'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + QCNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= dec;
    end
  end

endmodule

### src/awrt_back.sv
// ----------------------------------------------------------------------------
// Ack window tracker back end
// Executes queued commands against the link state and registers the result.
// ----------------------------------------------------------------------------
module awrt_back import awrt_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_valid,
  input  cmd_t        q_data,
  output logic        q_pop,
  input  logic [15:0] trig,
  awrt_out_if.source  out_ch
);

  link_t               mode_r, mode_nxt;
  logic [SEQ_W-1:0]    lseq_r, lseq_nxt;
  logic [WIN_BITS-1:0] rem_map_r, rem_map_nxt;
  logic [SEQ_W-1:0]    rcv_no_r, rcv_no_nxt;
  logic [WIN_BITS-1:0] rcv_map_r, rcv_map_nxt;
  logic [15:0]         tick_r, tick_nxt;
  logic                out_valid_r, out_valid_nxt;
  res_t                res_r, res_nxt;

  logic                do_tick;
  logic                sync_taken;
  logic [15:0]         tick_inc;
  logic [SEQ_W-1:0]    ack_d;
  logic [SEQ_W-1:0]    sh_d;
  logic [SEQ_W-1:0]    neg_mag;
  logic                sh_neg;
  logic [WIN_BITS-1:0] fresh;
  logic                zero_hit;
  logic [IDX_W-1:0]    zero_idx;

  assign q_pop = q_valid && (!out_valid_r || out_ch.ready);

  always_comb begin
    mode_nxt    = mode_r;
    lseq_nxt    = lseq_r;
    rem_map_nxt = rem_map_r;
    rcv_no_nxt  = rcv_no_r;
    rcv_map_nxt = rcv_map_r;
    tick_nxt    = tick_r;
    res_nxt     = '0;
    res_nxt.status = ST_DONE;
    do_tick     = 1'b0;
    sync_taken  = 1'b0;
    fresh       = '0;
    zero_hit    = 1'b0;
    zero_idx    = '0;
    tick_inc    = '0;

    ack_d   = lseq_r - q_data.pkt_ack_no;
    sh_d    = q_data.pkt_seq - rcv_no_r;
    neg_mag = SEQ_W'(0) - sh_d;
    sh_neg  = sh_d[SEQ_W-1] && !((sh_d == SEQ_HALF) && (q_data.pkt_seq > rcv_no_r));

    case (q_data.kind)
      CMD_CONNECT, CMD_SEND: begin
        if (mode_r == LINK_DOWN) begin
          rcv_map_nxt      = '0;
          rcv_no_nxt       = '0;
          lseq_nxt         = seq_next(lseq_r);
          rem_map_nxt      = {{(WIN_BITS-1){1'b1}}, 1'b0};
          mode_nxt         = LINK_SYNC;
          res_nxt.tx_valid = 1'b1;
          res_nxt.tx_sync  = 1'b1;
          res_nxt.tx_seq   = seq_next(lseq_r);
        end else if (q_data.kind == CMD_CONNECT) begin
          res_nxt.status = ST_IGNORED;
        end else if (mode_r == LINK_SYNC) begin
          res_nxt.status = ST_SYNCING;
        end else if (!rem_map_r[WIN_BITS-1]) begin
          res_nxt.status = ST_FULL;
        end else begin
          lseq_nxt         = seq_next(lseq_r);
          rem_map_nxt      = rem_map_r << 1;
          res_nxt.tx_valid = 1'b1;
          res_nxt.tx_seq   = seq_next(lseq_r);
        end
      end
      CMD_POLL: begin
        do_tick = 1'b1;
      end
      CMD_PKT_SYNC: begin
        do_tick = 1'b1;
        if (mode_r == LINK_SYNC) begin
          sync_taken  = 1'b1;
          mode_nxt    = LINK_UP;
          rcv_no_nxt  = q_data.pkt_seq;
          rcv_map_nxt = WIN_BITS'(1);
          rem_map_nxt = '1;
        end else begin
          res_nxt.status = ST_IGNORED;
        end
      end
      CMD_PKT_DATA: begin
        do_tick = 1'b1;
        if (ack_d < SEQ_W'(WIN_BITS)) begin
          fresh = (q_data.pkt_ack_window << ack_d[IDX_W-1:0]) & ~rem_map_r;
        end
        rem_map_nxt           = rem_map_r | fresh;
        res_nxt.released_mask = fresh;
        if (sh_d == '0) begin
          res_nxt.status = ST_OLD;
        end else if (sh_neg) begin
          if ((neg_mag >= SEQ_W'(WIN_BITS)) || rcv_map_r[neg_mag[IDX_W-1:0]]) begin
            res_nxt.status = ST_OLD;
          end else begin
            rcv_map_nxt     = rcv_map_r | (WIN_BITS'(1) << neg_mag[IDX_W-1:0]);
            res_nxt.deliver = 1'b1;
          end
        end else begin
          rcv_no_nxt      = q_data.pkt_seq;
          rcv_map_nxt     = (sh_d >= SEQ_W'(WIN_BITS)) ? WIN_BITS'(1) :
                            ((rcv_map_r << sh_d[IDX_W-1:0]) | WIN_BITS'(1));
          res_nxt.deliver = 1'b1;
        end
      end
      default: begin
        res_nxt.status = ST_IGNORED;
      end
    endcase

    if (do_tick) begin
      tick_inc = (sync_taken ? 16'd0 : tick_r) + 16'd1;
      if (tick_inc > trig) begin
        tick_nxt = '0;
        for (int i = 0; i < WIN_BITS; i++) begin
          if (!rem_map_nxt[i]) begin
            zero_hit = 1'b1;
            zero_idx = IDX_W'(i);
          end
        end
        res_nxt.resend_valid = zero_hit;
        if (zero_hit) begin
          res_nxt.resend_seq = (lseq_r > SEQ_W'(zero_idx)) ?
                               lseq_r - SEQ_W'(zero_idx) :
                               lseq_r - SEQ_W'(zero_idx) - SEQ_W'(1);
        end
      end else begin
        tick_nxt = tick_inc;
      end
    end

    res_nxt.hdr_ack_no     = rcv_no_nxt;
    res_nxt.hdr_ack_window = rcv_map_nxt;
    res_nxt.link_state     = mode_nxt;

    out_valid_nxt = out_valid_r;
    if (q_pop) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= LINK_DOWN;
      lseq_r      <= '0;
      rem_map_r   <= '1;
      rcv_no_r    <= '0;
      rcv_map_r   <= '0;
      tick_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (q_pop) begin
        mode_r    <= mode_nxt;
        lseq_r    <= lseq_nxt;
        rem_map_r <= rem_map_nxt;
        rcv_no_r  <= rcv_no_nxt;
        rcv_map_r <= rcv_map_nxt;
        tick_r    <= tick_nxt;
      end
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      res_r <= res_nxt;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.status         = res_r.status;
  assign out_ch.tx_valid       = res_r.tx_valid;
  assign out_ch.tx_sync        = res_r.tx_sync;
  assign out_ch.tx_seq         = res_r.tx_seq;
  assign out_ch.hdr_ack_no     = res_r.hdr_ack_no;
  assign out_ch.hdr_ack_window = res_r.hdr_ack_window;
  assign out_ch.released_mask  = res_r.released_mask;
  assign out_ch.deliver        = res_r.deliver;
  assign out_ch.resend_valid   = res_r.resend_valid;
  assign out_ch.resend_seq     = res_r.resend_seq;
  assign out_ch.link_state     = res_r.link_state;

endmodule
